// ===== src/gfrow_pkg.sv =====
`timescale 1ns / 1ps

package gfrow_pkg;

  // Matrix geometry
  localparam int ROWS  = 256;
  localparam int COLS  = 64;
  localparam int DEPTH = ROWS * COLS;

  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int COL_W    = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int KIND_W   = 3;
  localparam int ROW_IN_W = 8;
  localparam int COL_IN_W = 6;
  localparam int OCT_W    = 8;

  // Operation codes of an input word
  localparam logic [KIND_W-1:0] KIND_WRITE = KIND_W'(0);
  localparam logic [KIND_W-1:0] KIND_AXPY  = KIND_W'(1);
  localparam logic [KIND_W-1:0] KIND_SCALE = KIND_W'(2);
  localparam logic [KIND_W-1:0] KIND_SWAP  = KIND_W'(3);
  localparam logic [KIND_W-1:0] KIND_READ  = KIND_W'(4);

  // Source of the octet written into the matrix
  typedef enum logic [2:0] {
    WSEL_VALUE,
    WSEL_AXPY,
    WSEL_SCALE,
    WSEL_PORT_A,
    WSEL_PORT_B
  } wsel_e;

  // Controller to datapath command
  typedef struct packed {
    logic                rd_en;
    logic [ROW_IN_W-1:0] rd_row_a;
    logic [ROW_IN_W-1:0] rd_row_b;
    logic [COL_W-1:0]    rd_col;
    logic                wr_en;
    wsel_e               wr_sel;
    logic [ROW_IN_W-1:0] wr_row;
    logic [COL_W-1:0]    wr_col;
    logic [OCT_W-1:0]    factor;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [OCT_W-1:0] rdata_a;
  } dp_stat_t;

endpackage

// ===== src/gfrow_if.sv =====
`timescale 1ns / 1ps

// Operation channel
interface gfrow_req_if import gfrow_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [ROW_IN_W-1:0] dst_row;
  logic [ROW_IN_W-1:0] src_row;
  logic [COL_IN_W-1:0] col;
  logic [OCT_W-1:0]    value;

  modport source (output valid, kind, dst_row, src_row, col, value, input ready);
  modport sink   (input valid, kind, dst_row, src_row, col, value, output ready);
endinterface

// Result channel
interface gfrow_rsp_if import gfrow_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OCT_W-1:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink   (input valid, read_data, output ready);
endinterface

// ===== src/gfrow_dpath.sv =====
`timescale 1ns / 1ps

module gfrow_dpath import gfrow_pkg::*; (
  input  logic     clk_i,
  input  dp_cmd_t  cmd_i,
  output dp_stat_t stat_o
);

  // GF(256) multiply, reduction polynomial 0x11D
  function automatic logic [OCT_W-1:0] gf_mul(logic [OCT_W-1:0] a, logic [OCT_W-1:0] b);
    logic [OCT_W-1:0] x;
    logic [OCT_W-1:0] acc;
    x   = a;
    acc = '0;
    for (int k = 0; k < OCT_W; k++) begin
      if (b[k]) acc = acc ^ x;
      x = {x[OCT_W-2:0], 1'b0} ^ (x[OCT_W-1] ? 8'h1D : 8'h00);
    end
    return acc;
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(logic [ROW_IN_W-1:0] r,
                                                  logic [COL_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(COLS) + ADDR_W'(c);
  endfunction

  logic [OCT_W-1:0] mem_q [DEPTH];
  logic [OCT_W-1:0] rdata_a_q;
  logic [OCT_W-1:0] rdata_b_q;
  logic [OCT_W-1:0] mul_op;
  logic [OCT_W-1:0] product;
  logic [OCT_W-1:0] wdata;

  // Share one multiplier between axpy and scale
  assign mul_op  = (cmd_i.wr_sel == WSEL_AXPY) ? rdata_b_q : rdata_a_q;
  assign product = gf_mul(mul_op, cmd_i.factor);

  // Select write data
  always_comb begin
    unique case (cmd_i.wr_sel)
      WSEL_VALUE:  wdata = cmd_i.factor;
      WSEL_AXPY:   wdata = rdata_a_q ^ product;
      WSEL_SCALE:  wdata = product;
      WSEL_PORT_A: wdata = rdata_a_q;
      WSEL_PORT_B: wdata = rdata_b_q;
      default:     wdata = cmd_i.factor;
    endcase
  end

  // Matrix memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[cell_addr(cmd_i.wr_row, cmd_i.wr_col)] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_a_q <= mem_q[cell_addr(cmd_i.rd_row_a, cmd_i.rd_col)];
      rdata_b_q <= mem_q[cell_addr(cmd_i.rd_row_b, cmd_i.rd_col)];
    end
  end

  assign stat_o.rdata_a = rdata_a_q;

endmodule

// ===== src/gfrow_ctrl.sv =====
`timescale 1ns / 1ps

module gfrow_ctrl import gfrow_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  gfrow_req_if.sink  req_i,
  gfrow_rsp_if.source rsp_o,
  output dp_cmd_t    cmd_o,
  input  dp_stat_t   stat_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ELEM,
    S_RDWAIT,
    S_SWEEP,
    S_DONE
  } state_e;

  function automatic logic row_ok(logic [ROW_IN_W-1:0] r);
    return int'(r) < ROWS;
  endfunction

  function automatic logic col_ok(logic [COL_IN_W-1:0] c);
    return int'(c) < COLS;
  endfunction

  state_e              state_q, state_d;
  logic [KIND_W-1:0]   kind_q, kind_d;
  logic [ROW_IN_W-1:0] dst_q, dst_d;
  logic [ROW_IN_W-1:0] src_q, src_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic [OCT_W-1:0]    value_q, value_d;
  logic [COL_W-1:0]    cnt_q, cnt_d;
  logic [COL_W-1:0]    wcol_q, wcol_d;
  logic                more_q, more_d;
  logic                pend_q, pend_d;
  logic                phase_q, phase_d;
  logic [OCT_W-1:0]    res_q, res_d;
  logic                rsp_valid_q, rsp_valid_d;
  logic [OCT_W-1:0]    rsp_data_q, rsp_data_d;
  logic                last_col;

  assign req_i.ready     = (state_q == S_IDLE);
  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.read_data = rsp_data_q;
  assign last_col        = (cnt_q == COL_W'(COLS - 1));

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    dst_d       = dst_q;
    src_d       = src_q;
    col_d       = col_q;
    value_d     = value_q;
    cnt_d       = cnt_q;
    wcol_d      = wcol_q;
    more_d      = more_q;
    pend_d      = pend_q;
    phase_d     = phase_q;
    res_d       = res_q;
    rsp_valid_d = rsp_valid_q;
    rsp_data_d  = rsp_data_q;

    cmd_o          = '0;
    cmd_o.rd_row_a = dst_q;
    cmd_o.rd_row_b = src_q;
    cmd_o.rd_col   = cnt_q;
    cmd_o.wr_sel   = WSEL_VALUE;
    cmd_o.wr_row   = dst_q;
    cmd_o.wr_col   = wcol_q;
    cmd_o.factor   = value_q;

    // Drop the result word once taken
    if (rsp_valid_q && rsp_o.ready) rsp_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          kind_d  = req_i.kind;
          dst_d   = req_i.dst_row;
          src_d   = req_i.src_row;
          col_d   = COL_W'(req_i.col);
          value_d = req_i.value;
          res_d   = '0;
          cnt_d   = '0;
          more_d  = 1'b1;
          pend_d  = 1'b0;
          phase_d = 1'b0;
          // Decode the operation; out-of-range or unused ones finish at once
          unique case (req_i.kind)
            KIND_WRITE, KIND_READ:
              state_d = (row_ok(req_i.dst_row) && col_ok(req_i.col)) ? S_ELEM : S_DONE;
            KIND_AXPY:
              state_d = (row_ok(req_i.dst_row) && row_ok(req_i.src_row)) ? S_SWEEP : S_DONE;
            KIND_SCALE:
              state_d = row_ok(req_i.dst_row) ? S_SWEEP : S_DONE;
            KIND_SWAP:
              state_d = (row_ok(req_i.dst_row) && row_ok(req_i.src_row) &&
                         (req_i.dst_row != req_i.src_row)) ? S_SWEEP : S_DONE;
            default:
              state_d = S_DONE;
          endcase
        end
      end

      S_ELEM: begin
        if (kind_q == KIND_WRITE) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_col = col_q;
          state_d      = S_DONE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_col = col_q;
          state_d      = S_RDWAIT;
        end
      end

      S_RDWAIT: begin
        res_d   = stat_i.rdata_a;
        state_d = S_DONE;
      end

      S_SWEEP: begin
        if (!more_q && !pend_q) begin
          state_d = S_DONE;
        end else if (kind_q == KIND_SWAP) begin
          // Two writes per column: destination row, then source row
          if (!phase_q) begin
            cmd_o.rd_en  = more_q;
            cmd_o.wr_en  = pend_q;
            cmd_o.wr_row = src_q;
            cmd_o.wr_sel = WSEL_PORT_A;
            if (more_q) begin
              phase_d = 1'b1;
              pend_d  = 1'b1;
              wcol_d  = cnt_q;
              cnt_d   = cnt_q + COL_W'(1);
              more_d  = !last_col;
            end else begin
              pend_d  = 1'b0;
            end
          end else begin
            cmd_o.wr_en  = 1'b1;
            cmd_o.wr_row = dst_q;
            cmd_o.wr_sel = WSEL_PORT_B;
            phase_d      = 1'b0;
          end
        end else begin
          // Read one column while writing back the previous one
          cmd_o.rd_en  = more_q;
          cmd_o.wr_en  = pend_q;
          cmd_o.wr_sel = (kind_q == KIND_AXPY) ? WSEL_AXPY : WSEL_SCALE;
          pend_d       = more_q;
          if (more_q) begin
            wcol_d = cnt_q;
            cnt_d  = cnt_q + COL_W'(1);
            more_d = !last_col;
          end
        end
      end

      S_DONE: begin
        // Hand the result to the output register when it is free
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d = 1'b1;
          rsp_data_d  = res_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kind_q      <= '0;
      dst_q       <= '0;
      src_q       <= '0;
      col_q       <= '0;
      value_q     <= '0;
      cnt_q       <= '0;
      wcol_q      <= '0;
      more_q      <= 1'b0;
      pend_q      <= 1'b0;
      phase_q     <= 1'b0;
      res_q       <= '0;
      rsp_valid_q <= 1'b0;
      rsp_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      dst_q       <= dst_d;
      src_q       <= src_d;
      col_q       <= col_d;
      value_q     <= value_d;
      cnt_q       <= cnt_d;
      wcol_q      <= wcol_d;
      more_q      <= more_d;
      pend_q      <= pend_d;
      phase_q     <= phase_d;
      res_q       <= res_d;
      rsp_valid_q <= rsp_valid_d;
      rsp_data_q  <= rsp_data_d;
    end
  end

endmodule

// ===== src/gf256_matrix_row_operation_engine.sv =====
// An accepted word goes through S_ELEM (a write, or a read then S_RDWAIT) or S_SWEEP (axpy,
// scale, swap), then S_DONE; an unused kind or an out-of-range operand goes straight to S_DONE.
// One word at a time: the next word is taken only after the result
// enters the output register, which waits while the previous result is not yet taken.
// Row operations move one octet per cycle; a swap needs two writes per column.
// Reset (rst_ni, async, active low) clears control and the output register, not the matrix.
`timescale 1ns / 1ps

module gf256_matrix_row_operation_engine import gfrow_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  gfrow_req_if.sink   req_i,
  gfrow_rsp_if.source rsp_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer
  gfrow_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .rsp_o  (rsp_o),
    .cmd_o  (cmd),
    .stat_i (stat)
  );

  // Matrix memory and GF(256) arithmetic
  gfrow_dpath u_dpath (
    .clk_i  (clk_i),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

`ifndef ASSERT_OFF
  // One word in flight: no accept right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("word accepted while busy");

  // The matrix is only written while an operation is in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr_en |-> !req_i.ready)
    else $error("matrix write while idle");

  // A result appears only after the engine was busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(!req_i.ready))
    else $error("result without a finished operation");
`endif

endmodule

// ===== dv/gfrow_checker.sv =====
`timescale 1ns / 1ps

// Watches the operation and result channels, keeps a shadow copy of the octet
// matrix and checks every result word against the predicted read data.
module gfrow_checker import gfrow_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  gfrow_req_if        req_i,
  gfrow_rsp_if        rsp_i,
  output int          fail_count_o,
  output int          pending_o
);

  logic [OCT_W-1:0] shadow_matrix [ROWS][COLS];
  logic [OCT_W-1:0] read_data_q [$];
  int               mismatches;

  initial begin
    mismatches = 0;
    foreach (shadow_matrix[r, c]) shadow_matrix[r][c] = '0;
  end

  // Carry-less multiply with reduction by x^8+x^4+x^3+x^2+1
  function automatic logic [OCT_W-1:0] gf256_mul(input logic [OCT_W-1:0] a,
                                                 input logic [OCT_W-1:0] b);
    logic [OCT_W:0]   x;
    logic [OCT_W-1:0] acc;
    x   = {1'b0, a};
    acc = '0;
    for (int k = 0; k < OCT_W; k++) begin
      if (b[k]) acc ^= x[OCT_W-1:0];
      x = {x[OCT_W-1:0], 1'b0};
      if (x[OCT_W]) x ^= 9'h11D;
    end
    return acc;
  endfunction

  // Apply one operation word to the shadow matrix, return the read data it yields
  task automatic apply_row_op(input  logic [KIND_W-1:0]   kind,
                              input  logic [ROW_IN_W-1:0] dst,
                              input  logic [ROW_IN_W-1:0] src,
                              input  logic [COL_IN_W-1:0] col,
                              input  logic [OCT_W-1:0]    value,
                              output logic [OCT_W-1:0]    rd);
    logic [OCT_W-1:0] t;
    bit               dst_ok;
    bit               src_ok;
    bit               col_ok;
    rd     = '0;
    dst_ok = int'(dst) < ROWS;
    src_ok = int'(src) < ROWS;
    col_ok = int'(col) < COLS;
    case (kind)
      KIND_WRITE: begin
        if (dst_ok && col_ok) shadow_matrix[dst][col] = value;
      end
      KIND_AXPY: begin
        if (dst_ok && src_ok) begin
          for (int c = 0; c < COLS; c++)
            shadow_matrix[dst][c] ^= gf256_mul(shadow_matrix[src][c], value);
        end
      end
      KIND_SCALE: begin
        if (dst_ok) begin
          for (int c = 0; c < COLS; c++)
            shadow_matrix[dst][c] = gf256_mul(shadow_matrix[dst][c], value);
        end
      end
      KIND_SWAP: begin
        if (dst_ok && src_ok && dst != src) begin
          for (int c = 0; c < COLS; c++) begin
            t                    = shadow_matrix[dst][c];
            shadow_matrix[dst][c] = shadow_matrix[src][c];
            shadow_matrix[src][c] = t;
          end
        end
      end
      KIND_READ: begin
        if (dst_ok && col_ok) rd = shadow_matrix[dst][col];
      end
      default: ;
    endcase
  endtask

  function automatic void note_mismatch(input string what,
                                        input logic [OCT_W-1:0] exp_data,
                                        input logic [OCT_W-1:0] act_data);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected read_data %02h, got %02h",
               $realtime, what, exp_data, act_data);
  endfunction

  // Check result words first, then predict the word accepted at this edge
  always @(posedge clk_i) begin
    logic [OCT_W-1:0] exp_data;
    logic [OCT_W-1:0] rd;
    if (rst_ni) begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (read_data_q.size() == 0) begin
          note_mismatch("result word with nothing outstanding", '0, rsp_i.read_data);
        end else begin
          exp_data = read_data_q.pop_front();
          if (rsp_i.read_data !== exp_data)
            note_mismatch("read_data mismatch", exp_data, rsp_i.read_data);
        end
      end
      if (req_i.valid && req_i.ready) begin
        apply_row_op(req_i.kind, req_i.dst_row, req_i.src_row, req_i.col,
                     req_i.value, rd);
        read_data_q.push_back(rd);
      end
      pending_o    = read_data_q.size();
      fail_count_o = mismatches;
    end
  end

endmodule

// ===== dv/tb_gf256_matrix_row_operation_engine.sv =====
`timescale 1ns / 1ps

module tb_gf256_matrix_row_operation_engine;
  import gfrow_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = KIND_READ + KIND_W'(1);
  localparam logic [KIND_W-1:0] KIND_LAST        = '1;
  localparam int                WORDS_TO_SEND    = 400;
  localparam int                TAIL_CYCLES      = 2 * COLS + 12;
  localparam int                HOLD_CYCLES      = 400;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;

  // Sender gaps, receiver stalls and the long output hold-off
  bit   gaps_on;
  bit   stalls_on;
  bit   hold_off;

  // Entries that hold a defined value in the block, so reads stay legal
  bit   written [ROWS][COLS];
  int   sent_by_kind [1 << KIND_W];

  gfrow_req_if req_if ();
  gfrow_rsp_if rsp_if ();

  gf256_matrix_row_operation_engine dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  gfrow_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Offer one word and hold it until accepted, then track which entries are defined
  task automatic put_word(input logic [KIND_W-1:0]   kind,
                          input logic [ROW_IN_W-1:0] dst,
                          input logic [ROW_IN_W-1:0] src,
                          input logic [COL_IN_W-1:0] col,
                          input logic [OCT_W-1:0]    value);
    bit t;
    req_if.valid   <= 1'b1;
    req_if.kind    <= kind;
    req_if.dst_row <= dst;
    req_if.src_row <= src;
    req_if.col     <= col;
    req_if.value   <= value;
    do @(posedge clk_i); while (!req_if.ready);
    sent_by_kind[kind]++;
    case (kind)
      KIND_WRITE: written[dst][col] = 1'b1;
      KIND_AXPY: begin
        for (int c = 0; c < COLS; c++) written[dst][c] &= written[src][c];
      end
      KIND_SWAP: begin
        for (int c = 0; c < COLS; c++) begin
          t               = written[dst][c];
          written[dst][c] = written[src][c];
          written[src][c] = t;
        end
      end
      default: ;
    endcase
    // Drop valid for a random burst now and then
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  // Hold off the sender until every outstanding result word has come back
  task automatic drain_results();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Mostly a handful of hot rows so that written entries pile up; sometimes any row
  function automatic logic [ROW_IN_W-1:0] pick_row();
    if ($urandom_range(0, 3) == 0) return ROW_IN_W'($urandom_range(0, ROWS - 1));
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'h01;
      2:       return 8'h5A;
      3:       return 8'hA5;
      4:       return 8'hFE;
      default: return 8'hFF;
    endcase
  endfunction

  // One random operation; reads only target entries that were written
  task automatic random_word(output bit counted);
    int unsigned           pick;
    logic [ROW_IN_W-1:0]   r0;
    logic [ROW_IN_W-1:0]   r1;
    logic [COL_IN_W-1:0]   c;
    logic [OCT_W-1:0]      v;
    bit                    found;
    pick    = $urandom_range(0, 99);
    r0      = pick_row();
    r1      = pick_row();
    c       = COL_IN_W'($urandom_range(0, COLS - 1));
    v       = OCT_W'($urandom);
    counted = 1'b1;
    if (pick >= 38 && pick < 68) begin
      found = 1'b0;
      for (int k = 0; k < 32 && !found; k++) begin
        r0 = pick_row();
        c  = COL_IN_W'($urandom_range(0, COLS - 1));
        found = written[r0][c];
      end
      if (found) put_word(KIND_READ, r0, r1, c, v);
      else       put_word(KIND_WRITE, r0, r1, c, v);
    end else if (pick < 38) begin
      put_word(KIND_WRITE, r0, r1, c, v);
    end else if (pick < 80) begin
      put_word(KIND_AXPY, r0, r1, c, v);
    end else if (pick < 88) begin
      put_word(KIND_SCALE, r0, r1, c, v);
    end else if (pick < 96) begin
      put_word(KIND_SWAP, r0, r1, c, v);
    end else begin
      counted = 1'b0;
      put_word(KIND_W'($urandom_range(int'(KIND_SPARE_FIRST), int'(KIND_LAST))),
               r0, r1, c, v);
    end
  endtask

  // Result side: ready bursts, random stalls, and one long hold-off on request
  initial begin
    rsp_if.ready <= 1'b0;
    @(posedge clk_i);
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_off) begin
        hold_off = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (stalls_on && $urandom_range(0, 2) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end else begin
        rsp_if.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  initial begin
    #3_000_000;
    $display("[gf256_matrix_row_operation_engine] ERROR");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    int step;
    int done;
    bit counted;
    req_if.valid   <= 1'b0;
    req_if.kind    <= KIND_WRITE;
    req_if.dst_row <= '0;
    req_if.src_row <= '0;
    req_if.col     <= '0;
    req_if.value   <= '0;
    rst_ni         <= 1'b0;
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    hold_off  = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: corner rows and columns, every operation and the odd cases
    put_word(KIND_WRITE, 8'h00, 8'h00, 6'd0,  8'hFF);
    put_word(KIND_WRITE, 8'h00, 8'h00, 6'd63, 8'h80);
    put_word(KIND_WRITE, 8'hFF, 8'h00, 6'd63, 8'h01);
    put_word(KIND_WRITE, 8'hFF, 8'h00, 6'd0,  8'h53);
    put_word(KIND_READ,  8'h00, 8'h00, 6'd0,  8'h00);
    put_word(KIND_READ,  8'hFF, 8'h00, 6'd63, 8'h00);
    put_word(KIND_AXPY,  8'hFF, 8'h00, 6'd0,  8'h02);
    put_word(KIND_READ,  8'hFF, 8'h00, 6'd0,  8'h00);
    put_word(KIND_AXPY,  8'hFF, 8'h00, 6'd0,  8'h00);
    put_word(KIND_READ,  8'hFF, 8'h00, 6'd63, 8'h00);
    put_word(KIND_AXPY,  8'h00, 8'h00, 6'd0,  8'h03);
    put_word(KIND_READ,  8'h00, 8'h00, 6'd0,  8'h00);
    put_word(KIND_SCALE, 8'h00, 8'h00, 6'd0,  8'hFF);
    put_word(KIND_READ,  8'h00, 8'h00, 6'd63, 8'h00);
    put_word(KIND_SWAP,  8'h00, 8'hFF, 6'd0,  8'h00);
    put_word(KIND_READ,  8'h00, 8'h00, 6'd63, 8'h00);
    put_word(KIND_READ,  8'hFF, 8'h00, 6'd0,  8'h00);
    put_word(KIND_SWAP,  8'h00, 8'h00, 6'd0,  8'h00);
    put_word(KIND_READ,  8'h00, 8'h00, 6'd0,  8'h00);
    put_word(KIND_SCALE, 8'hFF, 8'h00, 6'd0,  8'h00);
    put_word(KIND_READ,  8'hFF, 8'h00, 6'd0,  8'h00);
    put_word(KIND_SCALE, 8'h00, 8'h00, 6'd0,  8'h01);
    put_word(KIND_SPARE_FIRST,          8'hFF, 8'hFF, 6'd63, 8'hFF);
    put_word(KIND_SPARE_FIRST + KIND_W'(1), 8'h00, 8'h00, 6'd0, 8'h00);
    put_word(KIND_LAST,  8'h00, 8'h00, 6'd63, 8'hFF);
    drain_results();

    // Random part, phased: stalls, a clean stretch, a long hold-off, a clean finish
    step = 0;
    done = 0;
    while (done < WORDS_TO_SEND) begin
      if (step == 100) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end
      if (step == 160) begin
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
      end
      if (step == 200) hold_off = 1'b1;
      if (step == 260) drain_results();
      if (step == 330) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end
      random_word(counted);
      if (counted) done++;
      step++;
    end
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d words: %0d writes, %0d axpy, %0d scale, %0d swap, %0d reads",
             step + 25, sent_by_kind[KIND_WRITE], sent_by_kind[KIND_AXPY],
             sent_by_kind[KIND_SCALE], sent_by_kind[KIND_SWAP], sent_by_kind[KIND_READ]);
    $display("with random gaps and stalls, a %0d-cycle output hold-off and drained pauses",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("[gf256_matrix_row_operation_engine] OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("[gf256_matrix_row_operation_engine] ERROR");
    end
    $finish;
  end

endmodule
